// ===== rtl/fpcp_pkg.sv =====
`timescale 1ns / 1ps

package fpcp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned OUT_USER_W = 3;

  localparam logic [POS_W-1:0] POS_FIRST    = 4'd0;
  localparam logic [POS_W-1:0] POS_NUMBER   = 4'd1;
  localparam logic [POS_W-1:0] POS_COMMAND  = 4'd2;
  localparam logic [POS_W-1:0] POS_SPEED_HI = 4'd3;
  localparam logic [POS_W-1:0] POS_SPEED_LO = 4'd4;
  localparam logic [POS_W-1:0] POS_RPM_HI   = 4'd5;
  localparam logic [POS_W-1:0] POS_RPM_LO   = 4'd6;
  localparam logic [POS_W-1:0] POS_FUEL     = 4'd7;
  localparam logic [POS_W-1:0] POS_TEMP     = 4'd8;
  localparam logic [POS_W-1:0] POS_IND      = 4'd9;
  localparam logic [POS_W-1:0] POS_CRC      = 4'd10;
  localparam logic [POS_W-1:0] POS_LAST     = 4'd11;
  localparam logic [POS_W-1:0] POS_IDLE     = 4'd12;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_MARKER = 2'd1,
    CAUSE_CRC    = 2'd2
  } reject_cause_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_MARKER = 3'd0,
    REG_STOP_MARKER  = 3'd1,
    REG_SENSOR_MASK  = 3'd2,
    REG_SPEED_LIMIT  = 3'd3,
    REG_RPM_LIMIT    = 3'd4,
    REG_TEST_COMMAND = 3'd5
  } cfg_reg_t;

  localparam logic [BYTE_W-1:0] RST_START_MARKER = 8'hAA;
  localparam logic [BYTE_W-1:0] RST_STOP_MARKER  = 8'h55;
  localparam logic [BYTE_W-1:0] RST_SENSOR_MASK  = 8'h01;
  localparam logic [WORD_W-1:0] RST_SPEED_LIMIT  = 16'd260;
  localparam logic [WORD_W-1:0] RST_RPM_LIMIT    = 16'd8000;
  localparam logic [BYTE_W-1:0] RST_TEST_COMMAND = 8'h01;

  function automatic logic [BYTE_W-1:0] crc8_fold(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/framed_packet_crc8_parser_unit.sv =====
`timescale 1ns / 1ps

// Latency: the result beat appears the cycle after the twelfth byte of a packet is accepted.
// Throughput: one byte per cycle; pre-CRC bytes get a CRC-8 fold, field bytes a capture.
// in_tready drops only while a held result waits on out_tready and pos_r sits at POS_LAST.
// Reset (rst_n low, synchronous): parser idle waiting for frame start, first frame pending,
// result register empty, configuration registers back to their defaults.
module framed_packet_crc8_parser_unit
  import fpcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] data_byte
  input  logic                  in_tuser,   // [0] frame_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] sequence_break, [8:1] frame_number, [16:9] command_code, [17] test_request,
  // [33:18] speed_value, [49:34] rpm_value, [57:50] fuel_value, [65:58] temp_value,
  // [73:66] indicator_bits, [79:74] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,  // [0] packet_ok, [2:1] reject_cause
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [BYTE_W-1:0] start_marker_r, stop_marker_r, sensor_mask_r, test_command_r;
  logic [WORD_W-1:0] speed_limit_r, rpm_limit_r;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] crc_r, crc_nxt;
  logic              marker_good_r, marker_good_nxt;
  logic              crc_good_r, crc_good_nxt;
  logic [BYTE_W-1:0] held_number_r, held_number_nxt;
  logic [BYTE_W-1:0] held_command_r, held_command_nxt;
  logic [WORD_W-1:0] held_speed_r, held_speed_nxt;
  logic [WORD_W-1:0] held_rpm_r, held_rpm_nxt;
  logic [BYTE_W-1:0] held_fuel_r, held_fuel_nxt;
  logic [BYTE_W-1:0] held_temp_r, held_temp_nxt;
  logic [BYTE_W-1:0] held_ind_r, held_ind_nxt;
  logic [BYTE_W-1:0] expected_r, expected_nxt;
  logic              first_frame_r, first_frame_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;

  logic              in_fire;
  logic              active;
  logic [POS_W-1:0]  pos_eff;
  logic [BYTE_W-1:0] b;
  logic              emit;
  logic              marker_final;
  reject_cause_t     cause;
  logic              seq_break;
  logic [WORD_W-1:0] spd, rpm;
  logic [BYTE_W-1:0] ind;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready || (pos_r != POS_LAST);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign b       = in_tdata;
  assign pos_eff = in_tuser ? POS_FIRST : pos_r;
  assign active  = in_tuser || (pos_r < POS_IDLE);
  assign emit    = in_fire && active && (pos_eff == POS_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= RST_START_MARKER;
      stop_marker_r  <= RST_STOP_MARKER;
      sensor_mask_r  <= RST_SENSOR_MASK;
      speed_limit_r  <= RST_SPEED_LIMIT;
      rpm_limit_r    <= RST_RPM_LIMIT;
      test_command_r <= RST_TEST_COMMAND;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_MARKER: start_marker_r <= cfg_data[BYTE_W-1:0];
        REG_STOP_MARKER:  stop_marker_r  <= cfg_data[BYTE_W-1:0];
        REG_SENSOR_MASK:  sensor_mask_r  <= cfg_data[BYTE_W-1:0];
        REG_SPEED_LIMIT:  speed_limit_r  <= cfg_data;
        REG_RPM_LIMIT:    rpm_limit_r    <= cfg_data;
        REG_TEST_COMMAND: test_command_r <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_nxt          = pos_r;
    crc_nxt          = crc_r;
    marker_good_nxt  = marker_good_r;
    crc_good_nxt     = crc_good_r;
    held_number_nxt  = held_number_r;
    held_command_nxt = held_command_r;
    held_speed_nxt   = held_speed_r;
    held_rpm_nxt     = held_rpm_r;
    held_fuel_nxt    = held_fuel_r;
    held_temp_nxt    = held_temp_r;
    held_ind_nxt     = held_ind_r;
    if (in_fire && active) begin
      if (pos_eff < POS_CRC) begin
        crc_nxt = crc8_fold((pos_eff == POS_FIRST) ? '0 : crc_r, b);
      end
      unique case (pos_eff)
        POS_FIRST:    marker_good_nxt  = (b == start_marker_r);
        POS_NUMBER:   held_number_nxt  = b;
        POS_COMMAND:  held_command_nxt = b;
        POS_SPEED_HI: held_speed_nxt   = {b, held_speed_r[BYTE_W-1:0]};
        POS_SPEED_LO: held_speed_nxt   = {held_speed_r[WORD_W-1:BYTE_W], b};
        POS_RPM_HI:   held_rpm_nxt     = {b, held_rpm_r[BYTE_W-1:0]};
        POS_RPM_LO:   held_rpm_nxt     = {held_rpm_r[WORD_W-1:BYTE_W], b};
        POS_FUEL:     held_fuel_nxt    = b;
        POS_TEMP:     held_temp_nxt    = b;
        POS_IND:      held_ind_nxt     = b;
        POS_CRC:      crc_good_nxt     = (crc_r == b);
        POS_LAST:     marker_good_nxt  = marker_good_r && (b == stop_marker_r);
        default: ;
      endcase
      pos_nxt = (pos_eff == POS_LAST) ? POS_IDLE : pos_eff + 4'd1;
    end
  end

  always_comb begin
    marker_final = marker_good_r && (b == stop_marker_r);
    if (!marker_final) begin
      cause = CAUSE_MARKER;
    end else if (!crc_good_r) begin
      cause = CAUSE_CRC;
    end else begin
      cause = CAUSE_NONE;
    end
    seq_break = !first_frame_r && (held_number_r != expected_r);
    spd = (held_speed_r >= speed_limit_r) ? speed_limit_r : held_speed_r;
    rpm = (held_rpm_r >= rpm_limit_r) ? rpm_limit_r : held_rpm_r;
    ind = (rpm == '0) ? (held_ind_r ^ sensor_mask_r) : held_ind_r;

    expected_nxt    = expected_r;
    first_frame_nxt = first_frame_r;
    out_data_nxt    = out_data_r;
    out_user_nxt    = out_user_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_user_nxt  = {cause, cause == CAUSE_NONE};
      out_data_nxt  = '0;
      if (cause == CAUSE_NONE) begin
        out_data_nxt[0]     = seq_break;
        out_data_nxt[8:1]   = held_number_r;
        out_data_nxt[16:9]  = held_command_r;
        out_data_nxt[17]    = (held_command_r == test_command_r);
        out_data_nxt[33:18] = spd;
        out_data_nxt[49:34] = rpm;
        out_data_nxt[57:50] = held_fuel_r;
        out_data_nxt[65:58] = held_temp_r;
        out_data_nxt[73:66] = ind;
        expected_nxt        = held_number_r + 8'd1;
        first_frame_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r           <= POS_IDLE;
      crc_r           <= '0;
      marker_good_r   <= 1'b0;
      crc_good_r      <= 1'b0;
      held_number_r   <= '0;
      held_command_r  <= '0;
      held_speed_r    <= '0;
      held_rpm_r      <= '0;
      held_fuel_r     <= '0;
      held_temp_r     <= '0;
      held_ind_r      <= '0;
      expected_r      <= '0;
      first_frame_r   <= 1'b1;
      out_valid_r     <= 1'b0;
    end else begin
      pos_r           <= pos_nxt;
      crc_r           <= crc_nxt;
      marker_good_r   <= marker_good_nxt;
      crc_good_r      <= crc_good_nxt;
      held_number_r   <= held_number_nxt;
      held_command_r  <= held_command_nxt;
      held_speed_r    <= held_speed_nxt;
      held_rpm_r      <= held_rpm_nxt;
      held_fuel_r     <= held_fuel_nxt;
      held_temp_r     <= held_temp_nxt;
      held_ind_r      <= held_ind_nxt;
      expected_r      <= expected_nxt;
      first_frame_r   <= first_frame_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_IDLE)
    else $error("byte position out of range");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && !out_tready)) |-> $past(emit))
    else $error("result beat without a completed packet");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_user_r[0]) |-> (out_data_r == '0 && out_user_r[2:1] != CAUSE_NONE))
    else $error("rejected packet carries field data");

  a_seq_track: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && cause == CAUSE_NONE) |=>
      (!first_frame_r && expected_r == $past(held_number_r) + 8'd1))
    else $error("sequence tracking not updated");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && pos_r == POS_LAST) |-> !in_tready)
    else $error("input taken while result stalled");

endmodule

// ===== tb/tb_framed_packet_crc8_parser_unit.sv =====
`timescale 1ns / 1ps

module tb_framed_packet_crc8_parser_unit;
  import fpcp_pkg::*;

  localparam logic [BYTE_W-1:0] DASH_POLY = 8'h07;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int NUM_PHASES     = 5;
  localparam int PHASE_BYTES    = 290;
  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLD_LEN       = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DIR_ROWS       = 11;
  localparam int MAX_PRINTS     = 40;

  typedef logic [11:0][BYTE_W-1:0] frame_t;

  typedef struct {
    logic              ok;
    reject_cause_t     cause;
    logic              brk;
    logic [BYTE_W-1:0] number;
    logic [BYTE_W-1:0] command;
    logic              test_req;
    logic [WORD_W-1:0] speed;
    logic [WORD_W-1:0] rpm;
    logic [BYTE_W-1:0] fuel;
    logic [BYTE_W-1:0] temp;
    logic [BYTE_W-1:0] ind;
  } dash_result_t;

  typedef struct {
    logic              first_fs;
    int                nbytes;
    logic [BYTE_W-1:0] start;
    logic [BYTE_W-1:0] number;
    logic [BYTE_W-1:0] command;
    logic [WORD_W-1:0] speed;
    logic [WORD_W-1:0] rpm;
    logic [BYTE_W-1:0] fuel;
    logic [BYTE_W-1:0] temp;
    logic [BYTE_W-1:0] ind;
    logic [BYTE_W-1:0] stop;
    logic [BYTE_W-1:0] crc_flip;
    bit                typed;
    dash_result_t      exp;
  } dash_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  framed_packet_crc8_parser_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dash_result_t pending_results[$];
  int mismatches   = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_ticket  = 0;

  logic [BYTE_W-1:0] cfg_start     = RST_START_MARKER;
  logic [BYTE_W-1:0] cfg_stop      = RST_STOP_MARKER;
  logic [BYTE_W-1:0] cfg_mask      = RST_SENSOR_MASK;
  logic [WORD_W-1:0] cfg_speed_lim = RST_SPEED_LIMIT;
  logic [WORD_W-1:0] cfg_rpm_lim   = RST_RPM_LIMIT;
  logic [BYTE_W-1:0] cfg_test_cmd  = RST_TEST_COMMAND;

  logic [POS_W-1:0]  m_pos        = POS_IDLE;
  logic [BYTE_W-1:0] m_crc        = '0;
  logic              m_marker_ok  = 1'b0;
  logic              m_crc_ok     = 1'b0;
  logic [BYTE_W-1:0] m_number     = '0;
  logic [BYTE_W-1:0] m_command    = '0;
  logic [WORD_W-1:0] m_speed      = '0;
  logic [WORD_W-1:0] m_rpm        = '0;
  logic [BYTE_W-1:0] m_fuel       = '0;
  logic [BYTE_W-1:0] m_temp       = '0;
  logic [BYTE_W-1:0] m_ind        = '0;
  logic [BYTE_W-1:0] m_exp_number = '0;
  logic              m_first      = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    logic fb;
    c = crc;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = c[BYTE_W-1] ^ b[i];
      c = {c[BYTE_W-2:0], 1'b0};
      if (fb) begin
        c = c ^ DASH_POLY;
      end
    end
    return c;
  endfunction

  function automatic dash_result_t cleared_result(input reject_cause_t cause);
    dash_result_t r;
    r.ok = 1'b0;
    r.cause = cause;
    r.brk = 1'b0;
    r.number = '0;
    r.command = '0;
    r.test_req = 1'b0;
    r.speed = '0;
    r.rpm = '0;
    r.fuel = '0;
    r.temp = '0;
    r.ind = '0;
    return r;
  endfunction

  function automatic void parse_byte(input logic [BYTE_W-1:0] b, input logic fs,
                                     output logic got, output dash_result_t r);
    logic [POS_W-1:0] p;
    got = 1'b0;
    r = cleared_result(CAUSE_NONE);
    if (fs) begin
      m_pos = POS_FIRST;
    end else if (m_pos >= POS_IDLE) begin
      return;
    end
    p = m_pos;
    if (p < POS_CRC) begin
      m_crc = crc8_step((p == POS_FIRST) ? 8'h00 : m_crc, b);
    end
    case (p)
      POS_FIRST:    m_marker_ok = (b == cfg_start);
      POS_NUMBER:   m_number = b;
      POS_COMMAND:  m_command = b;
      POS_SPEED_HI: m_speed[15:8] = b;
      POS_SPEED_LO: m_speed[7:0] = b;
      POS_RPM_HI:   m_rpm[15:8] = b;
      POS_RPM_LO:   m_rpm[7:0] = b;
      POS_FUEL:     m_fuel = b;
      POS_TEMP:     m_temp = b;
      POS_IND:      m_ind = b;
      POS_CRC:      m_crc_ok = (m_crc == b);
      default: ;
    endcase
    if (p < POS_LAST) begin
      m_pos = p + 4'd1;
      return;
    end
    m_pos = POS_IDLE;
    m_marker_ok = m_marker_ok && (b == cfg_stop);
    got = 1'b1;
    if (!m_marker_ok) begin
      r = cleared_result(CAUSE_MARKER);
    end else if (!m_crc_ok) begin
      r = cleared_result(CAUSE_CRC);
    end else begin
      r.ok = 1'b1;
      r.brk = !m_first && (m_number != m_exp_number);
      r.number = m_number;
      r.command = m_command;
      r.test_req = (m_command == cfg_test_cmd);
      r.speed = (m_speed >= cfg_speed_lim) ? cfg_speed_lim : m_speed;
      r.rpm = (m_rpm >= cfg_rpm_lim) ? cfg_rpm_lim : m_rpm;
      r.fuel = m_fuel;
      r.temp = m_temp;
      r.ind = (r.rpm == 16'd0) ? (m_ind ^ cfg_mask) : m_ind;
      m_exp_number = m_number + 8'd1;
      m_first = 1'b0;
    end
  endfunction

  function automatic frame_t build_frame(input logic [BYTE_W-1:0] start,
                                         input logic [BYTE_W-1:0] number,
                                         input logic [BYTE_W-1:0] command,
                                         input logic [WORD_W-1:0] speed,
                                         input logic [WORD_W-1:0] rpm,
                                         input logic [BYTE_W-1:0] fuel,
                                         input logic [BYTE_W-1:0] temp,
                                         input logic [BYTE_W-1:0] ind,
                                         input logic [BYTE_W-1:0] stop,
                                         input logic [BYTE_W-1:0] crc_flip);
    frame_t f;
    logic [BYTE_W-1:0] c;
    f[0] = start;
    f[1] = number;
    f[2] = command;
    f[3] = speed[15:8];
    f[4] = speed[7:0];
    f[5] = rpm[15:8];
    f[6] = rpm[7:0];
    f[7] = fuel;
    f[8] = temp;
    f[9] = ind;
    c = 8'h00;
    for (int i = 0; i < 10; i++) begin
      c = crc8_step(c, f[i]);
    end
    f[10] = c ^ crc_flip;
    f[11] = stop;
    return f;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word(input logic [WORD_W-1:0] lim);
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return lim;
      3: return lim + 16'd1;
      4: return lim - 16'd1;
      5: return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    if (mismatches < MAX_PRINTS) begin
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    end
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  task automatic check_result();
    dash_result_t got;
    dash_result_t want;
    got.ok = out_tuser[0];
    got.cause = reject_cause_t'(out_tuser[2:1]);
    got.brk = out_tdata[0];
    got.number = out_tdata[8:1];
    got.command = out_tdata[16:9];
    got.test_req = out_tdata[17];
    got.speed = out_tdata[33:18];
    got.rpm = out_tdata[49:34];
    got.fuel = out_tdata[57:50];
    got.temp = out_tdata[65:58];
    got.ind = out_tdata[73:66];
    if (pending_results.size() == 0) begin
      report_mismatch("result beat with nothing pending", out_tdata[15:0], 16'h0000);
      return;
    end
    want = pending_results.pop_front();
    check_field("packet_ok", 16'(got.ok), 16'(want.ok));
    check_field("reject_cause", 16'(got.cause), 16'(want.cause));
    check_field("sequence_break", 16'(got.brk), 16'(want.brk));
    check_field("frame_number", 16'(got.number), 16'(want.number));
    check_field("command_code", 16'(got.command), 16'(want.command));
    check_field("test_request", 16'(got.test_req), 16'(want.test_req));
    check_field("speed_value", got.speed, want.speed);
    check_field("rpm_value", got.rpm, want.rpm);
    check_field("fuel_value", 16'(got.fuel), 16'(want.fuel));
    check_field("temp_value", 16'(got.temp), 16'(want.temp));
    check_field("indicator_bits", 16'(got.ind), 16'(want.ind));
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fs, input bit typed,
                           input dash_result_t fixed);
    logic got;
    dash_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= fs;
    do @(posedge clk); while (!in_tready);
    parse_byte(b, fs, got, r);
    if (got) begin
      pending_results.push_back(typed ? fixed : r);
    end
  endtask

  task automatic send_frame(input frame_t f, input int nbytes, input logic first_fs,
                            input int fs_pos, input bit typed, input dash_result_t fixed);
    for (int i = 0; i < nbytes; i++) begin
      send_byte(f[i], (i == 0) ? first_fs : (i == fs_pos), typed && (i == 11), fixed);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_MARKER: cfg_start = val[7:0];
      REG_STOP_MARKER:  cfg_stop = val[7:0];
      REG_SENSOR_MASK:  cfg_mask = val[7:0];
      REG_SPEED_LIMIT:  cfg_speed_lim = val;
      REG_RPM_LIMIT:    cfg_rpm_lim = val;
      REG_TEST_COMMAND: cfg_test_cmd = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [BYTE_W-1:0] start, input logic [BYTE_W-1:0] stop,
                              input logic [BYTE_W-1:0] mask, input logic [WORD_W-1:0] spd_lim,
                              input logic [WORD_W-1:0] rpm_lim,
                              input logic [BYTE_W-1:0] test_cmd);
    write_reg(REG_SPARE_6, 16'($urandom));
    write_reg(REG_START_MARKER, {8'($urandom), start});
    write_reg(REG_STOP_MARKER, {8'($urandom), stop});
    write_reg(REG_SENSOR_MASK, {8'($urandom), mask});
    write_reg(REG_SPEED_LIMIT, spd_lim);
    write_reg(REG_RPM_LIMIT, rpm_lim);
    write_reg(REG_TEST_COMMAND, {8'($urandom), test_cmd});
    write_reg(REG_SPARE_7, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_packet(inout int sent);
    int kind;
    int nbytes;
    int fs_pos;
    frame_t f;
    logic [BYTE_W-1:0] st;
    logic [BYTE_W-1:0] sp;
    logic [BYTE_W-1:0] flip;
    logic [BYTE_W-1:0] num;
    logic [BYTE_W-1:0] cmd;
    kind = $urandom_range(99);
    num = ($urandom_range(7) == 0) ? 8'($urandom) : m_exp_number;
    cmd = ($urandom_range(1) == 0) ? cfg_test_cmd : 8'($urandom);
    st = cfg_start;
    sp = cfg_stop;
    flip = 8'h00;
    nbytes = 12;
    fs_pos = -1;
    if (kind >= 72 && kind < 78) begin
      st = cfg_start ^ 8'($urandom_range(1, 255));
    end else if (kind >= 78 && kind < 84) begin
      sp = cfg_stop ^ 8'($urandom_range(1, 255));
    end else if (kind >= 84 && kind < 90) begin
      flip = 8'($urandom_range(1, 255));
    end else if (kind >= 90 && kind < 94) begin
      nbytes = $urandom_range(1, 11);
    end else if (kind >= 94 && kind < 97) begin
      fs_pos = $urandom_range(1, 11);
    end else if (kind >= 97) begin
      repeat ($urandom_range(1, 3)) begin
        send_byte(8'($urandom), $urandom_range(3) == 0, 1'b0, cleared_result(CAUSE_NONE));
      end
      return;
    end
    f = build_frame(st, num, cmd, pick_word(cfg_speed_lim), pick_word(cfg_rpm_lim),
                    8'($urandom), 8'($urandom), 8'($urandom), sp, flip);
    send_frame(f, nbytes, 1'b1, fs_pos, 1'b0, cleared_result(CAUSE_NONE));
    sent += nbytes;
  endtask

  task automatic run_directed();
    dash_row_t rows [DIR_ROWS];
    dash_result_t accepted;
    frame_t f;
    accepted.ok = 1'b1;
    accepted.cause = CAUSE_NONE;
    accepted.brk = 1'b0;
    accepted.number = 8'h00;
    accepted.command = 8'h01;
    accepted.test_req = 1'b1;
    accepted.speed = 16'd260;
    accepted.rpm = 16'd8000;
    accepted.fuel = 8'hFF;
    accepted.temp = 8'h00;
    accepted.ind = 8'h00;
    // stray byte while idle, then the reset-value extremes and each reject cause
    rows[0] = '{1'b0, 1, 8'hFF, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00,
                8'h55, 8'h00, 1'b0, cleared_result(CAUSE_NONE)};
    rows[1] = '{1'b1, 12, 8'hAA, 8'h00, 8'h01, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h00, 8'h00,
                8'h55, 8'h00, 1'b1, accepted};
    rows[2] = '{1'b1, 12, 8'h55, 8'h01, 8'h00, 16'h0010, 16'h0010, 8'h10, 8'h10, 8'h10,
                8'h55, 8'h00, 1'b1, cleared_result(CAUSE_MARKER)};
    rows[3] = '{1'b1, 12, 8'hAA, 8'h01, 8'h00, 16'h0010, 16'h0010, 8'h10, 8'h10, 8'h10,
                8'hAA, 8'h00, 1'b1, cleared_result(CAUSE_MARKER)};
    rows[4] = '{1'b1, 12, 8'hAA, 8'h01, 8'h00, 16'h0010, 16'h0010, 8'h10, 8'h10, 8'h10,
                8'h55, 8'h01, 1'b1, cleared_result(CAUSE_CRC)};
    rows[5] = '{1'b1, 12, 8'h00, 8'h01, 8'h00, 16'h0010, 16'h0010, 8'h10, 8'h10, 8'h10,
                8'h55, 8'hFF, 1'b1, cleared_result(CAUSE_MARKER)};
    // cut short, dropped by the next frame start
    rows[6] = '{1'b1, 6, 8'hAA, 8'h01, 8'h00, 16'h0010, 16'h0010, 8'h10, 8'h10, 8'h10,
                8'h55, 8'h00, 1'b0, cleared_result(CAUSE_NONE)};
    rows[7] = '{1'b1, 12, 8'hAA, 8'h01, 8'hFE, 16'h0000, 16'h0000, 8'h00, 8'hFF, 8'hFE,
                8'h55, 8'h00, 1'b0, cleared_result(CAUSE_NONE)};
    rows[8] = '{1'b1, 12, 8'hAA, 8'h07, 8'h80, 16'd259, 16'd7999, 8'h5A, 8'hA5, 8'hFF,
                8'h55, 8'h00, 1'b0, cleared_result(CAUSE_NONE)};
    rows[9] = '{1'b1, 12, 8'hAA, 8'hFF, 8'h7F, 16'd260, 16'd8000, 8'h01, 8'h80, 8'h01,
                8'h55, 8'h00, 1'b0, cleared_result(CAUSE_NONE)};
    rows[10] = '{1'b1, 12, 8'hAA, 8'h00, 8'h01, 16'd261, 16'd8001, 8'hC3, 8'h3C, 8'h80,
                 8'h55, 8'h00, 1'b0, cleared_result(CAUSE_NONE)};
    for (int i = 0; i < DIR_ROWS; i++) begin
      f = build_frame(rows[i].start, rows[i].number, rows[i].command, rows[i].speed,
                      rows[i].rpm, rows[i].fuel, rows[i].temp, rows[i].ind, rows[i].stop,
                      rows[i].crc_flip);
      send_frame(f, rows[i].nbytes, rows[i].first_fs, -1, rows[i].typed, rows[i].exp);
    end
  endtask

  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        check_result();
      end
      if (hold_seen != hold_ticket) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb_framed_packet_crc8_parser_unit NOT OK");
    $finish;
  end

  initial begin
    int sent;
    bit paused;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          apply_config(8'h00, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 8'hFF);
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          apply_config(8'hFF, 8'h00, 8'h80, 16'hFFFF, 16'hFFFF, 8'h00);
          tx_idle_pct = 76;
          rx_stall_pct = 0;
        end
        2: begin
          apply_config(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                       16'($urandom_range(1023)), 8'($urandom));
          tx_idle_pct = 0;
          rx_stall_pct = 76;
          hold_ticket <= hold_ticket + 1;
        end
        3: begin
          apply_config(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(511)),
                       16'($urandom), 8'($urandom));
          tx_idle_pct = 36;
          rx_stall_pct = 36;
        end
        default: begin
          apply_config(RST_START_MARKER, RST_STOP_MARKER, RST_SENSOR_MASK, RST_SPEED_LIMIT,
                       RST_RPM_LIMIT, RST_TEST_COMMAND);
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
      endcase
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_BYTES) begin
        random_packet(sent);
        // hold the sender until every pending result is out
        if (ph == 3 && !paused && sent >= PHASE_BYTES / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end
    wait_drained();
    if (mismatches == 0) begin
      $display("tb_framed_packet_crc8_parser_unit OK");
    end else begin
      $display("tb_framed_packet_crc8_parser_unit NOT OK");
    end
    $finish;
  end

endmodule
